// File: hw/rtl/ttf_pkg.sv
// ttf_pkg: widths, state codes and vertex phase codes for triangle_tangent_frame.
// No dependencies.
package ttf_pkg;

  localparam int CW        = 32;
  localparam int OW        = 32;
  localparam int NB        = 31;
  localparam int US        = 30;
  localparam int MW        = (CW + 1 > NB + 1) ? CW + 1 : NB + 1;
  localparam int PW        = 2 * MW;
  localparam int VW        = PW + 2;
  localparam int SUM_W     = 2 * NB + 2;
  localparam int LEN_W     = SUM_W / 2;
  localparam int NUM_W     = NB + US + 1;
  localparam int QW        = US + 1;
  localparam int DREM_W    = LEN_W + 2;
  localparam int SQRT_IT   = SUM_W / 2;
  localparam int IT_W      = $clog2(SQRT_IT);
  localparam int NTERMS    = 14;
  localparam int K_W       = $clog2(NTERMS);

  localparam logic [1:0] PH_V0 = 2'd0;
  localparam logic [1:0] PH_V1 = 2'd1;
  localparam logic [1:0] PH_V2 = 2'd2;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_MUL   = 12'b000000000010,
    S_ACC   = 12'b000000000100,
    S_SIGN  = 12'b000000001000,
    S_LOAD  = 12'b000000010000,
    S_SHIFT = 12'b000000100000,
    S_SQ    = 12'b000001000000,
    S_SQACC = 12'b000010000000,
    S_SQRT  = 12'b000100000000,
    S_DIVI  = 12'b001000000000,
    S_DIV   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

endpackage

// File: hw/rtl/triangle_tangent_frame.sv
// triangle_tangent_frame: per-triangle unit tangent and bitangent from a vertex stream.
// Uses ttf_pkg. One shared multiplier, bit-serial square root and divider.
// The first two vertices of a triangle are only registered; the third starts the work,
// whose length is set by the square root and the three divisions per vector.
// One triangle in flight at a time.
// Reset (rst_n low, synchronous) clears the sequencer, vertex phase and output valid.
module triangle_tangent_frame (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [ttf_pkg::CW-1:0]  in_pos_x,
  input  logic signed [ttf_pkg::CW-1:0]  in_pos_y,
  input  logic signed [ttf_pkg::CW-1:0]  in_pos_z,
  input  logic signed [ttf_pkg::CW-1:0]  in_tex_u,
  input  logic signed [ttf_pkg::CW-1:0]  in_tex_v,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [ttf_pkg::OW-1:0]  out_tangent_x,
  output logic signed [ttf_pkg::OW-1:0]  out_tangent_y,
  output logic signed [ttf_pkg::OW-1:0]  out_tangent_z,
  output logic signed [ttf_pkg::OW-1:0]  out_bitangent_x,
  output logic signed [ttf_pkg::OW-1:0]  out_bitangent_y,
  output logic signed [ttf_pkg::OW-1:0]  out_bitangent_z,
  output logic                           out_degenerate
);

  ttf_pkg::state_t state_r, state_nxt;

  logic signed [ttf_pkg::CW-1:0]   in_p [3];
  logic signed [ttf_pkg::CW-1:0]   p0_r [3];
  logic signed [ttf_pkg::CW-1:0]   p1_r [3];
  logic signed [ttf_pkg::CW-1:0]   uv0_r [2];
  logic signed [ttf_pkg::CW-1:0]   uv1_r [2];
  logic [1:0]                      phase_r;
  logic signed [ttf_pkg::CW:0]     e1_r [3];
  logic signed [ttf_pkg::CW:0]     e2_r [3];
  logic signed [ttf_pkg::CW:0]     du1_r, dv1_r, du2_r, dv2_r;
  logic [ttf_pkg::K_W-1:0]         k_r;
  logic                            tb_sel;
  logic [1:0]                      ti;
  logic [2:0]                      dst;
  logic signed [ttf_pkg::MW-1:0]   mul_a, mul_b;
  logic signed [ttf_pkg::PW-1:0]   mul_p, prod_r;
  logic signed [ttf_pkg::VW-1:0]   prod_v, acc_base, acc_new;
  logic signed [ttf_pkg::VW-1:0]   det_r;
  logic signed [ttf_pkg::VW-1:0]   vec_r [6];
  logic signed [ttf_pkg::VW-1:0]   comp [3];
  logic                            vsel_r;
  logic [ttf_pkg::VW-1:0]          mag_r [3];
  logic                            neg_r [3];
  logic [ttf_pkg::VW-1:0]          mx;
  logic [1:0]                      c_r;
  logic [ttf_pkg::SUM_W-1:0]       sum_r, res_r, bit_r, trial, res_step;
  logic                            sq_ge;
  logic [ttf_pkg::IT_W-1:0]        it_r;
  logic [ttf_pkg::LEN_W-1:0]       len_r;
  logic [ttf_pkg::NUM_W-1:0]       numer;
  logic [ttf_pkg::DREM_W-1:0]      drem_r, r2;
  logic                            dv_ge;
  logic [ttf_pkg::QW-1:0]          num_r, q_r, q_nxt;
  logic [ttf_pkg::OW-1:0]          qo;
  logic [2:0]                      uidx;
  logic signed [ttf_pkg::OW-1:0]   uvec_r [6];
  logic                            degen_r;
  logic                            out_valid_r, out_deg_r;
  logic signed [ttf_pkg::OW-1:0]   out_t_r [3];
  logic signed [ttf_pkg::OW-1:0]   out_b_r [3];
  logic                            in_acc, out_load;

  assign in_p = '{in_pos_x, in_pos_y, in_pos_z};
  assign in_stall = (state_r != ttf_pkg::S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_load = (state_r == ttf_pkg::S_DONE) && (!out_valid_r || !out_stall);

  // product term selection
  always_comb begin
    tb_sel = (k_r >= ttf_pkg::K_W'(8));
    ti = tb_sel ? 2'((k_r - ttf_pkg::K_W'(8)) >> 1) : 2'((k_r - ttf_pkg::K_W'(2)) >> 1);
    if (state_r == ttf_pkg::S_SQ) begin
      mul_a = {{(ttf_pkg::MW - ttf_pkg::NB){1'b0}}, mag_r[c_r][ttf_pkg::NB-1:0]};
      mul_b = mul_a;
    end else if (k_r < ttf_pkg::K_W'(2)) begin
      mul_a = ttf_pkg::MW'(k_r[0] ? du2_r : du1_r);
      mul_b = ttf_pkg::MW'(k_r[0] ? dv1_r : dv2_r);
    end else if (!tb_sel) begin
      mul_a = ttf_pkg::MW'(k_r[0] ? dv1_r : dv2_r);
      mul_b = ttf_pkg::MW'(k_r[0] ? e2_r[ti] : e1_r[ti]);
    end else begin
      mul_a = ttf_pkg::MW'(k_r[0] ? du2_r : du1_r);
      mul_b = ttf_pkg::MW'(k_r[0] ? e1_r[ti] : e2_r[ti]);
    end
  end

  assign mul_p    = mul_a * mul_b;
  assign dst      = 3'((k_r - ttf_pkg::K_W'(2)) >> 1);
  assign prod_v   = ttf_pkg::VW'(prod_r);
  assign acc_base = (k_r < ttf_pkg::K_W'(2)) ? det_r : vec_r[dst];
  assign acc_new  = k_r[0] ? acc_base - prod_v : prod_v;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      comp[i] = vsel_r ? vec_r[3 + i] : vec_r[i];
    end
  end

  assign mx = mag_r[0] | mag_r[1] | mag_r[2];

  assign trial    = res_r + bit_r;
  assign sq_ge    = (sum_r >= trial);
  assign res_step = sq_ge ? (res_r >> 1) + bit_r : res_r >> 1;

  assign numer = {mag_r[c_r][ttf_pkg::NB-1:0], {ttf_pkg::US{1'b0}}}
               + ttf_pkg::NUM_W'(len_r >> 1);
  assign r2    = {drem_r[ttf_pkg::DREM_W-2:0], num_r[ttf_pkg::QW-1]};
  assign dv_ge = (r2 >= ttf_pkg::DREM_W'(len_r));
  assign q_nxt = {q_r[ttf_pkg::QW-2:0], dv_ge};
  assign qo    = neg_r[c_r] ? -ttf_pkg::OW'(q_nxt) : ttf_pkg::OW'(q_nxt);
  assign uidx  = (vsel_r ? 3'd3 : 3'd0) + {1'b0, c_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ttf_pkg::S_IDLE:
        if (in_acc && !(phase_r == ttf_pkg::PH_V0 || phase_r == ttf_pkg::PH_V1)) begin
          state_nxt = ttf_pkg::S_MUL;
        end
      ttf_pkg::S_MUL: state_nxt = ttf_pkg::S_ACC;
      ttf_pkg::S_ACC:
        state_nxt = (k_r == ttf_pkg::K_W'(ttf_pkg::NTERMS - 1)) ? ttf_pkg::S_SIGN
                                                               : ttf_pkg::S_MUL;
      ttf_pkg::S_SIGN:
        state_nxt = (det_r == '0) ? ttf_pkg::S_DONE : ttf_pkg::S_LOAD;
      ttf_pkg::S_LOAD: begin
        if (comp[0] == '0 && comp[1] == '0 && comp[2] == '0) begin
          state_nxt = ttf_pkg::S_DONE;
        end else begin
          state_nxt = ttf_pkg::S_SHIFT;
        end
      end
      ttf_pkg::S_SHIFT:
        if (mx[ttf_pkg::VW-1:ttf_pkg::NB] == '0 && mx[ttf_pkg::NB-1]) begin
          state_nxt = ttf_pkg::S_SQ;
        end
      ttf_pkg::S_SQ: state_nxt = ttf_pkg::S_SQACC;
      ttf_pkg::S_SQACC:
        state_nxt = (c_r == 2'd2) ? ttf_pkg::S_SQRT : ttf_pkg::S_SQ;
      ttf_pkg::S_SQRT:
        if (it_r == ttf_pkg::IT_W'(ttf_pkg::SQRT_IT - 1)) begin
          state_nxt = ttf_pkg::S_DIVI;
        end
      ttf_pkg::S_DIVI: state_nxt = ttf_pkg::S_DIV;
      ttf_pkg::S_DIV:
        if (it_r == ttf_pkg::IT_W'(ttf_pkg::QW - 1)) begin
          if (c_r != 2'd2) begin
            state_nxt = ttf_pkg::S_DIVI;
          end else begin
            state_nxt = vsel_r ? ttf_pkg::S_DONE : ttf_pkg::S_LOAD;
          end
        end
      ttf_pkg::S_DONE:
        if (out_load) begin
          state_nxt = ttf_pkg::S_IDLE;
        end
      default: state_nxt = ttf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttf_pkg::S_IDLE;
      phase_r     <= ttf_pkg::PH_V0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (phase_r == ttf_pkg::PH_V0) begin
          phase_r <= ttf_pkg::PH_V1;
        end else if (phase_r == ttf_pkg::PH_V1) begin
          phase_r <= ttf_pkg::PH_V2;
        end else begin
          phase_r <= ttf_pkg::PH_V0;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ttf_pkg::S_IDLE:
        if (in_acc) begin
          if (phase_r == ttf_pkg::PH_V0) begin
            p0_r  <= in_p;
            uv0_r <= '{in_tex_u, in_tex_v};
          end else if (phase_r == ttf_pkg::PH_V1) begin
            p1_r  <= in_p;
            uv1_r <= '{in_tex_u, in_tex_v};
          end else begin
            for (int i = 0; i < 3; i++) begin
              e1_r[i] <= (ttf_pkg::CW + 1)'(p1_r[i]) - (ttf_pkg::CW + 1)'(p0_r[i]);
              e2_r[i] <= (ttf_pkg::CW + 1)'(in_p[i]) - (ttf_pkg::CW + 1)'(p0_r[i]);
            end
            du1_r   <= (ttf_pkg::CW + 1)'(uv1_r[0]) - (ttf_pkg::CW + 1)'(uv0_r[0]);
            dv1_r   <= (ttf_pkg::CW + 1)'(uv1_r[1]) - (ttf_pkg::CW + 1)'(uv0_r[1]);
            du2_r   <= (ttf_pkg::CW + 1)'(in_tex_u) - (ttf_pkg::CW + 1)'(uv0_r[0]);
            dv2_r   <= (ttf_pkg::CW + 1)'(in_tex_v) - (ttf_pkg::CW + 1)'(uv0_r[1]);
            k_r     <= '0;
            vsel_r  <= 1'b0;
            degen_r <= 1'b0;
          end
        end
      ttf_pkg::S_MUL: prod_r <= mul_p;
      ttf_pkg::S_ACC: begin
        if (k_r < ttf_pkg::K_W'(2)) begin
          det_r <= acc_new;
        end else begin
          vec_r[dst] <= acc_new;
        end
        k_r <= k_r + ttf_pkg::K_W'(1);
      end
      ttf_pkg::S_SIGN: begin
        if (det_r == '0) begin
          degen_r <= 1'b1;
        end else if (det_r < 0) begin
          for (int i = 0; i < 6; i++) begin
            vec_r[i] <= -vec_r[i];
          end
        end
      end
      ttf_pkg::S_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= comp[i] < 0;
          mag_r[i] <= (comp[i] < 0) ? ttf_pkg::VW'(-comp[i]) : ttf_pkg::VW'(comp[i]);
        end
        if (comp[0] == '0 && comp[1] == '0 && comp[2] == '0) begin
          degen_r <= 1'b1;
        end
      end
      ttf_pkg::S_SHIFT: begin
        for (int i = 0; i < 3; i++) begin
          if (mx[ttf_pkg::VW-1:ttf_pkg::NB] != '0) begin
            mag_r[i] <= mag_r[i] >> 1;
          end else if (!mx[ttf_pkg::NB-1]) begin
            mag_r[i] <= mag_r[i] << 1;
          end
        end
        c_r   <= 2'd0;
        sum_r <= '0;
      end
      ttf_pkg::S_SQ: prod_r <= mul_p;
      ttf_pkg::S_SQACC: begin
        sum_r <= sum_r + prod_r[ttf_pkg::SUM_W-1:0];
        c_r   <= c_r + 2'd1;
        res_r <= '0;
        bit_r <= ttf_pkg::SUM_W'(1) << (ttf_pkg::SUM_W - 2);
        it_r  <= '0;
      end
      ttf_pkg::S_SQRT: begin
        if (sq_ge) begin
          sum_r <= sum_r - trial;
        end
        res_r <= res_step;
        bit_r <= bit_r >> 2;
        it_r  <= it_r + ttf_pkg::IT_W'(1);
        len_r <= ttf_pkg::LEN_W'(res_step);
        c_r   <= 2'd0;
      end
      ttf_pkg::S_DIVI: begin
        drem_r <= ttf_pkg::DREM_W'(numer[ttf_pkg::NUM_W-1:ttf_pkg::QW]);
        num_r  <= numer[ttf_pkg::QW-1:0];
        q_r    <= '0;
        it_r   <= '0;
      end
      ttf_pkg::S_DIV: begin
        drem_r <= dv_ge ? r2 - ttf_pkg::DREM_W'(len_r) : r2;
        num_r  <= num_r << 1;
        q_r    <= q_nxt;
        it_r   <= it_r + ttf_pkg::IT_W'(1);
        if (it_r == ttf_pkg::IT_W'(ttf_pkg::QW - 1)) begin
          uvec_r[uidx] <= qo;
          if (c_r == 2'd2) begin
            vsel_r <= 1'b1;
          end
          c_r <= c_r + 2'd1;
        end
      end
      ttf_pkg::S_DONE:
        if (out_load) begin
          for (int i = 0; i < 3; i++) begin
            out_t_r[i] <= degen_r ? '0 : uvec_r[i];
            out_b_r[i] <= degen_r ? '0 : uvec_r[3 + i];
          end
          out_deg_r <= degen_r;
        end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_tangent_x   = out_t_r[0];
  assign out_tangent_y   = out_t_r[1];
  assign out_tangent_z   = out_t_r[2];
  assign out_bitangent_x = out_b_r[0];
  assign out_bitangent_y = out_b_r[1];
  assign out_bitangent_z = out_b_r[2];
  assign out_degenerate  = out_deg_r;

  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ttf_pkg::S_DONE))
    else $error("result valid rose outside completion");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_deg_r |-> out_t_r[0] == '0 && out_t_r[1] == '0 &&
      out_t_r[2] == '0 && out_b_r[0] == '0 && out_b_r[1] == '0 && out_b_r[2] == '0)
    else $error("degenerate result with nonzero vectors");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_deg_r |-> out_t_r[0] <= 32'sd1073741824 &&
      out_t_r[0] >= -32'sd1073741824 && out_b_r[0] <= 32'sd1073741824 &&
      out_b_r[0] >= -32'sd1073741824)
    else $error("unit component out of range");

  a_phase_valid: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == ttf_pkg::PH_V0 || phase_r == ttf_pkg::PH_V1 || phase_r == ttf_pkg::PH_V2)
    else $error("vertex phase invalid");

endmodule
